[hw/rtl/mvd_pkg.sv]
package mvd_pkg;

  // Binarization constants (UEG3, signed, prefix cutoff 9)
  localparam logic [3:0]  PrefixCutoff  = 4'd9;
  localparam logic [4:0]  EgOrder       = 5'd3;
  localparam logic [4:0]  MaxEscapeOnes = 5'd12;
  localparam logic [16:0] MagLimit      = 17'd32767;

  // Thresholds on the neighbor magnitude sum for the first bin
  localparam logic [18:0] CtxSumLow  = 19'd3;
  localparam logic [18:0] CtxSumHigh = 19'd32;

  // Context offsets of the later prefix bins
  localparam logic [3:0] CtxSatOnes   = 4'd4;
  localparam logic [2:0] CtxOffsetSat = 3'd6;
  localparam logic [2:0] CtxBinBase   = 3'd2;

  // Configuration register index
  localparam logic RegMbaffEnable = 1'b0;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PREFIX = 3'd1,
    PH_EUNARY = 3'd2,
    PH_EBITS  = 3'd3,
    PH_SIGN   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_REQ      = 2'd0,
    ST_DONE     = 2'd1,
    ST_BIN_IDLE = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic {
    FN_START = 1'b0,
    FN_BIN   = 1'b1
  } func_e;

  typedef struct packed {
    logic               func;
    logic               bin;
    logic               component;
    logic               cur_field;
    logic               a_avail;
    logic               a_field;
    logic signed [15:0] a_mvd;
    logic               b_avail;
    logic               b_field;
    logic signed [15:0] b_mvd;
  } mvd_in_t;

  typedef struct packed {
    status_e            status;
    logic               bypass;
    logic [2:0]         ctx_offset;
    logic               component_out;
    logic signed [15:0] mvd_value;
  } mvd_out_t;

endpackage

[hw/rtl/mvd_cabac_debinarizer.sv]
// CABAC mvd debinarizer (UEG3, cutoff 9, bypass sign).
// The result beat of an item appears in the cycle after the item is accepted.
// Throughput: 1 item per cycle unless the output stalls; bin state loops back.
// The single output register accepts a new item while its beat is taken.
// Reset (rst_ni low, async): idle phase, all counters zero, mbaff_enable 0, no output.
module mvd_cabac_debinarizer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  mvd_pkg::mvd_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mvd_pkg::mvd_out_t out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mvd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  ones_q, ones_d;
  logic [4:0]  order_q, order_d;
  logic [4:0]  suffix_q, suffix_d;
  logic [16:0] mag_q, mag_d;
  logic        comp_q, comp_d;
  logic        mbaff_q;

  logic        out_valid_q;
  mvd_out_t    out_data_q;
  mvd_out_t    res;

  logic        in_fire;
  logic [1:0]  ctx_inc;
  logic [3:0]  ones_inc;
  logic [4:0]  order_inc;
  logic [17:0] eu_sum;
  logic        eu_fail;
  logic [4:0]  eb_pos;
  logic [17:0] eb_sum;
  logic        eb_fail;
  logic [16:0] mag_neg;

  // Config port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == RegMbaffEnable) begin
      prdata = {31'd0, mbaff_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbaff_q <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == RegMbaffEnable)) begin
      mbaff_q <= pwdata[0];
    end
  end

  // Handshake: stall only while a result beat is held back
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;

  mvd_ctxinc u_ctxinc (
    .mbaff_i   (mbaff_q),
    .item_i    (in_data_i),
    .ctx_inc_o (ctx_inc)
  );

  // Shared datapath terms
  assign ones_inc  = ones_q + 4'd1;
  assign order_inc = order_q + 5'd1;
  assign eu_sum    = {1'b0, mag_q} + (18'd1 << order_q);
  assign eu_fail   = ((order_inc - EgOrder) > MaxEscapeOnes) || (eu_sum > {1'b0, MagLimit});
  assign eb_pos    = (suffix_q != 5'd0) ? (suffix_q - 5'd1) : 5'd0;
  assign eb_sum    = {1'b0, mag_q} + ({17'd0, in_data_i.bin} << eb_pos);
  assign eb_fail   = eb_sum > {1'b0, MagLimit};
  assign mag_neg   = 17'd0 - mag_q;

  // Next state
  always_comb begin
    phase_d  = phase_q;
    ones_d   = ones_q;
    order_d  = order_q;
    suffix_d = suffix_q;
    mag_d    = mag_q;
    comp_d   = comp_q;
    if (in_data_i.func == FN_START) begin
      phase_d  = PH_PREFIX;
      ones_d   = '0;
      order_d  = '0;
      suffix_d = '0;
      mag_d    = '0;
      comp_d   = in_data_i.component;
    end else begin
      case (phase_q)
        PH_PREFIX: begin
          if (!in_data_i.bin) begin
            if (ones_q == 4'd0) begin
              phase_d = PH_IDLE;
            end else begin
              mag_d   = {13'd0, ones_q};
              phase_d = PH_SIGN;
            end
          end else begin
            ones_d = ones_inc;
            if (ones_inc >= PrefixCutoff) begin
              mag_d   = {13'd0, PrefixCutoff};
              order_d = EgOrder;
              phase_d = PH_EUNARY;
            end
          end
        end
        PH_EUNARY: begin
          if (in_data_i.bin) begin
            mag_d   = eu_sum[16:0];
            order_d = order_inc;
            if (eu_fail) begin
              phase_d = PH_IDLE;
            end
          end else begin
            suffix_d = order_q;
            phase_d  = PH_EBITS;
          end
        end
        PH_EBITS: begin
          suffix_d = eb_pos;
          mag_d    = eb_sum[16:0];
          if (eb_fail) begin
            phase_d = PH_IDLE;
          end else if (eb_pos == 5'd0) begin
            phase_d = PH_SIGN;
          end
        end
        PH_SIGN: begin
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // Result beat
  always_comb begin
    res               = '0;
    res.status        = ST_REQ;
    res.component_out = comp_q;
    if (in_data_i.func == FN_START) begin
      res.ctx_offset    = {1'b0, ctx_inc};
      res.component_out = in_data_i.component;
    end else begin
      case (phase_q)
        PH_PREFIX: begin
          if (!in_data_i.bin) begin
            if (ones_q == 4'd0) begin
              res.status = ST_DONE;
            end else begin
              res.bypass = 1'b1;
            end
          end else if (ones_inc >= PrefixCutoff) begin
            res.bypass = 1'b1;
          end else if (ones_inc >= CtxSatOnes) begin
            res.ctx_offset = CtxOffsetSat;
          end else begin
            res.ctx_offset = ones_inc[2:0] + CtxBinBase;
          end
        end
        PH_EUNARY: begin
          if (in_data_i.bin && eu_fail) begin
            res.status = ST_OVERFLOW;
          end else begin
            res.bypass = 1'b1;
          end
        end
        PH_EBITS: begin
          if (eb_fail) begin
            res.status = ST_OVERFLOW;
          end else begin
            res.bypass = 1'b1;
          end
        end
        PH_SIGN: begin
          res.status    = ST_DONE;
          res.mvd_value = in_data_i.bin ? mag_neg[15:0] : mag_q[15:0];
        end
        default: begin
          res.status        = ST_BIN_IDLE;
          res.component_out = 1'b0;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      ones_q   <= '0;
      order_q  <= '0;
      suffix_q <= '0;
      mag_q    <= '0;
      comp_q   <= 1'b0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      ones_q   <= ones_d;
      order_q  <= order_d;
      suffix_q <= suffix_d;
      mag_q    <= mag_d;
      comp_q   <= comp_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  a_start_gives_ctx_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.func == FN_START |=>
      out_valid_o && out_data_o.status == ST_REQ && !out_data_o.bypass)
    else $error("start beat did not yield a context request");

  a_idle_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.func == FN_BIN && phase_q == PH_IDLE |=>
      out_data_o.status == ST_BIN_IDLE && phase_q == PH_IDLE)
    else $error("bin while idle mishandled");

  a_bypass_no_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bypass |->
      out_data_o.ctx_offset == 3'd0 && out_data_o.status == ST_REQ)
    else $error("bypass request carries a context offset");

  a_ctx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.ctx_offset <= CtxOffsetSat)
    else $error("context offset out of range");

  a_mag_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_EUNARY || phase_q == PH_EBITS || phase_q == PH_SIGN |->
      mag_q <= MagLimit)
    else $error("magnitude above limit while active");

endmodule

[hw/rtl/mvd_ctxinc.sv]
module mvd_ctxinc (
  input  logic            mbaff_i,
  input  mvd_pkg::mvd_in_t item_i,
  output logic [1:0]      ctx_inc_o
);
  import mvd_pkg::*;

  logic [16:0] abs_a;
  logic [16:0] abs_b;
  logic [17:0] scl_a;
  logic [17:0] scl_b;
  logic [18:0] sum;
  logic        scale_en;

  // Magnitudes of the neighbor mvds, zero when unavailable
  always_comb begin
    abs_a = item_i.a_mvd[15] ? (17'd0 - {item_i.a_mvd[15], item_i.a_mvd})
                             : {1'b0, item_i.a_mvd};
    abs_b = item_i.b_mvd[15] ? (17'd0 - {item_i.b_mvd[15], item_i.b_mvd})
                             : {1'b0, item_i.b_mvd};
    if (!item_i.a_avail) begin
      abs_a = '0;
    end
    if (!item_i.b_avail) begin
      abs_b = '0;
    end
  end

  // MBAFF vertical scaling: field neighbor of frame MB doubles, frame of field halves
  assign scale_en = mbaff_i & item_i.component;

  always_comb begin
    scl_a = {1'b0, abs_a};
    scl_b = {1'b0, abs_b};
    if (scale_en) begin
      if (!item_i.cur_field && item_i.a_field) begin
        scl_a = {abs_a, 1'b0};
      end else if (item_i.cur_field && !item_i.a_field) begin
        scl_a = {2'b00, abs_a[16:1]};
      end
      if (!item_i.cur_field && item_i.b_field) begin
        scl_b = {abs_b, 1'b0};
      end else if (item_i.cur_field && !item_i.b_field) begin
        scl_b = {2'b00, abs_b[16:1]};
      end
    end
  end

  assign sum = {1'b0, scl_a} + {1'b0, scl_b};

  // Increment 0, 1 or 2 from the sum
  always_comb begin
    if (sum < CtxSumLow) begin
      ctx_inc_o = 2'd0;
    end else if (sum <= CtxSumHigh) begin
      ctx_inc_o = 2'd1;
    end else begin
      ctx_inc_o = 2'd2;
    end
  end

endmodule
